// ----- sv/wheel_six_prime_generator_core_defines.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the wheel-six prime generator
// Shared property wrappers, clocked on aclk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef WHEEL_SIX_PRIME_GENERATOR_CORE_DEFINES_SVH
`define WHEEL_SIX_PRIME_GENERATOR_CORE_DEFINES_SVH

// Same-cycle implication.
`define WSP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("wheel_six_prime_generator_core: assertion failed");

// Next-cycle implication.
`define WSP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("wheel_six_prime_generator_core: assertion failed");

`endif

// ----- sv/wsp_gen_pkg.sv -----
// ---------------------------------------------------------------------------
// Wheel-six prime generator package
// Types, register indexes, seed primes and stream widths.
// ---------------------------------------------------------------------------
package wsp_gen_pkg;

    // Stream and register port widths.
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 40;
    localparam int CFG_ADDR_W  = 1;
    localparam int CFG_DATA_W  = 32;

    // Register indexes.
    localparam logic [CFG_ADDR_W-1:0] REG_SCAN_START = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_SCAN_END   = 1'b1;

    // Register reset values, the wheel size, the seed count and the last seed.
    localparam int SCAN_START_RST = 10;
    localparam int SCAN_END_RST   = 100;
    localparam int BLOCK_SIZE     = 6;
    localparam int SEED_COUNT     = 4;
    localparam int LAST_SEED      = 7;

    // Sequencer states, one-hot.
    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_MOD   = 7'b0000010,
        S_FETCH = 7'b0000100,
        S_LOAD  = 7'b0001000,
        S_DIV   = 7'b0010000,
        S_EVAL  = 7'b0100000,
        S_EMIT  = 7'b1000000
    } state_t;

    // The primes the table is reseeded with.
    function automatic logic [31:0] seed_prime(input logic [1:0] idx);
        logic [31:0] val;
        case (idx)
            2'd0:    val = 32'd2;
            2'd1:    val = 32'd3;
            2'd2:    val = 32'd5;
            default: val = 32'd7;
        endcase
        return val;
    endfunction

endpackage

// ----- sv/wheel_six_prime_generator_core.sv -----
// A restart beat reduces the start modulo six in S_MOD, reseeding the table, then
// passes S_EMIT to its result beat. An advance beat runs S_FETCH, S_LOAD, S_DIV
// and S_EVAL for every stored prime tried on each of its two candidates; one
// restoring divider does all tests. The core takes one beat at a time; the next
// beat is taken in the cycle the result appears.
// Reset (synchronous, aresetn low) idles the scan and restores config/control regs.
// ---------------------------------------------------------------------------
// Wheel-six prime generator core
// Tests 6k-1 and 6k+1 by trial division against a self-built prime table.
// The prime table is reseeded by each restart beat.
// ---------------------------------------------------------------------------
module wheel_six_prime_generator_core #(
    parameter int TABLE_DEPTH = 1024,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // Configuration write port.
    input  logic                                   cfg_wr_en,
    input  logic [wsp_gen_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [wsp_gen_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
    // Input beats.
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [wsp_gen_pkg::IN_TDATA_W-1:0]     s_tdata,  // [0] restart
    // Result beats.
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // [31:0] block_center, [32] low_is_prime, [33] high_is_prime,
    // [34] table_exhausted, [35] table_full, [36] scan_done
    output logic [wsp_gen_pkg::OUT_TDATA_W-1:0]    m_tdata
);
    import wsp_gen_pkg::*;

    localparam int W   = VALUE_WIDTH;
    localparam int PW  = VALUE_WIDTH + 1;
    localparam int AW  = $clog2(TABLE_DEPTH);
    localparam int CW  = $clog2(TABLE_DEPTH + 1);
    localparam int BW  = $clog2(VALUE_WIDTH);
    localparam int DCW = $clog2(PW + 1);

    state_t          state_reg, state_next;
    logic [W-1:0]    start_reg, end_reg;
    logic [PW-1:0]   pos_reg, pos_next;
    logic            active_reg, active_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [W-1:0]    last_reg, last_next;
    logic [PW-1:0]   cand_reg, cand_next;
    logic [PW-1:0]   center_reg, center_next;
    logic [CW-1:0]   idx_reg, idx_next;
    logic            test_hi_reg, test_hi_next;
    logic            lo_p_reg, lo_p_next;
    logic            hi_p_reg, hi_p_next;
    logic            exh_reg, exh_next;
    logic            full_reg, full_next;
    logic            done_reg, done_next;
    logic [W-1:0]    mod_sh_reg, mod_sh_next;
    logic [2:0]      mod_r_reg, mod_r_next;
    logic [BW-1:0]   bcnt_reg, bcnt_next;
    logic [PW-1:0]   div_n_reg, div_n_next;
    logic [W-1:0]    div_rem_reg, div_rem_next;
    logic [W-1:0]    div_p_reg, div_p_next;
    logic [DCW-1:0]  div_cnt_reg, div_cnt_next;
    logic            m_tvalid_reg, m_tvalid_next;
    logic [OUT_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    // Prime table.
    logic [W-1:0]    mem [TABLE_DEPTH];
    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    logic [W-1:0]    mem_wdata;
    logic [W-1:0]    mem_rdata_reg;

    // Divider step: shift in the next dividend bit and try a subtract.
    logic [W:0]      div_trial;
    logic            div_ge;
    logic [W:0]      div_diff;
    assign div_trial = {div_rem_reg, div_n_reg[PW-1]};
    assign div_ge    = (div_trial >= {1'b0, div_p_reg});
    assign div_diff  = div_trial - {1'b0, div_p_reg};

    logic [31+PW:0]  center_ext;
    assign center_ext = {32'b0, center_reg};

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Table memory, registered read.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= mem[idx_reg[AW-1:0]];
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg <= W'(SCAN_START_RST);
            end_reg   <= W'(SCAN_END_RST);
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_SCAN_START: start_reg <= cfg_wr_data[W-1:0];
                REG_SCAN_END:   end_reg   <= cfg_wr_data[W-1:0];
            endcase
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            pos_reg      <= '0;
            active_reg   <= 1'b0;
            count_reg    <= CW'(SEED_COUNT);
            last_reg     <= W'(LAST_SEED);
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            pos_reg      <= pos_next;
            active_reg   <= active_next;
            count_reg    <= count_next;
            last_reg     <= last_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Working registers.
    always_ff @(posedge aclk) begin
        cand_reg    <= cand_next;
        center_reg  <= center_next;
        idx_reg     <= idx_next;
        test_hi_reg <= test_hi_next;
        lo_p_reg    <= lo_p_next;
        hi_p_reg    <= hi_p_next;
        exh_reg     <= exh_next;
        full_reg    <= full_next;
        done_reg    <= done_next;
        mod_sh_reg  <= mod_sh_next;
        mod_r_reg   <= mod_r_next;
        bcnt_reg    <= bcnt_next;
        div_n_reg   <= div_n_next;
        div_rem_reg <= div_rem_next;
        div_p_reg   <= div_p_next;
        div_cnt_reg <= div_cnt_next;
        m_tdata_reg <= m_tdata_next;
    end

    // Sequencer.
    always_comb begin
        logic [3:0]    r2;
        logic [2:0]    r_new;
        logic [2:0]    adj;
        logic          test_over;
        logic          test_res;
        logic [31:0]   seed;
        logic [CW-1:0] idx_inc;

        state_next    = state_reg;
        pos_next      = pos_reg;
        active_next   = active_reg;
        count_next    = count_reg;
        last_next     = last_reg;
        cand_next     = cand_reg;
        center_next   = center_reg;
        idx_next      = idx_reg;
        test_hi_next  = test_hi_reg;
        lo_p_next     = lo_p_reg;
        hi_p_next     = hi_p_reg;
        exh_next      = exh_reg;
        full_next     = full_reg;
        done_next     = done_reg;
        mod_sh_next   = mod_sh_reg;
        mod_r_next    = mod_r_reg;
        bcnt_next     = bcnt_reg;
        div_n_next    = div_n_reg;
        div_rem_next  = div_rem_reg;
        div_p_next    = div_p_reg;
        div_cnt_next  = div_cnt_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        mem_we        = 1'b0;
        mem_waddr     = count_reg[AW-1:0];
        mem_wdata     = cand_reg[W-1:0];
        r2            = '0;
        r_new         = '0;
        adj           = '0;
        test_over     = 1'b0;
        test_res      = 1'b0;
        seed          = '0;
        idx_inc       = idx_reg + CW'(1);

        // The result beat leaves as soon as the far side takes it.
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    lo_p_next = 1'b0;
                    hi_p_next = 1'b0;
                    exh_next  = 1'b0;
                    full_next = 1'b0;
                    done_next = 1'b0;
                    if (s_tdata[0]) begin
                        // Restart: reduce the start modulo six bit by bit.
                        mod_sh_next = start_reg;
                        mod_r_next  = '0;
                        bcnt_next   = '0;
                        state_next  = S_MOD;
                    end else if (!active_reg) begin
                        center_next = '0;
                        done_next   = 1'b1;
                        state_next  = S_EMIT;
                    end else if (pos_reg >= {1'b0, end_reg}) begin
                        active_next = 1'b0;
                        center_next = pos_reg;
                        done_next   = 1'b1;
                        state_next  = S_EMIT;
                    end else if (pos_reg == '0) begin
                        // Neither -1 nor 1 is prime.
                        center_next = pos_reg;
                        pos_next    = pos_reg + PW'(BLOCK_SIZE);
                        state_next  = S_EMIT;
                    end else begin
                        center_next  = pos_reg;
                        cand_next    = pos_reg - PW'(1);
                        test_hi_next = 1'b0;
                        idx_next     = '0;
                        state_next   = S_FETCH;
                    end
                end
            end

            S_MOD: begin
                r2 = {mod_r_reg, mod_sh_reg[W-1]};
                r_new = (r2 >= 4'(BLOCK_SIZE)) ? 3'(r2 - 4'(BLOCK_SIZE)) : r2[2:0];
                mod_r_next  = r_new;
                mod_sh_next = {mod_sh_reg[W-2:0], 1'b0};
                bcnt_next   = bcnt_reg + BW'(1);
                // Reseed the table during the first four steps.
                if (bcnt_reg < BW'(SEED_COUNT)) begin
                    seed      = seed_prime(bcnt_reg[1:0]);
                    mem_we    = 1'b1;
                    mem_waddr = AW'(bcnt_reg[1:0]);
                    mem_wdata = seed[W-1:0];
                end
                if (bcnt_reg == BW'(W - 1)) begin
                    adj         = (r_new == 3'd0) ? 3'd0 : 3'(BLOCK_SIZE) - r_new;
                    pos_next    = {1'b0, start_reg} + PW'(adj);
                    center_next = {1'b0, start_reg} + PW'(adj);
                    active_next = 1'b1;
                    count_next  = CW'(SEED_COUNT);
                    last_next   = W'(LAST_SEED);
                    state_next  = S_EMIT;
                end
            end

            S_FETCH: begin
                state_next = S_LOAD;
            end

            S_LOAD: begin
                div_p_next   = mem_rdata_reg;
                div_n_next   = cand_reg;
                div_rem_next = '0;
                div_cnt_next = '0;
                state_next   = S_DIV;
            end

            S_DIV: begin
                div_rem_next = div_ge ? div_diff[W-1:0] : div_trial[W-1:0];
                div_n_next   = {div_n_reg[PW-2:0], div_ge};
                div_cnt_next = div_cnt_reg + DCW'(1);
                if (div_cnt_reg == DCW'(PW - 1)) begin
                    state_next = S_EVAL;
                end
            end

            S_EVAL: begin
                // Quotient below divisor means p*p exceeds the candidate.
                if (div_n_reg < {1'b0, div_p_reg}) begin
                    test_over = 1'b1;
                    test_res  = 1'b1;
                end else if (div_rem_reg == '0) begin
                    test_over = 1'b1;
                end else if (idx_inc == count_reg) begin
                    test_over = 1'b1;
                    exh_next  = 1'b1;
                end else begin
                    idx_next   = idx_inc;
                    state_next = S_FETCH;
                end

                if (test_over) begin
                    // Append a new prime above the last stored entry.
                    if (test_res && (cand_reg > {1'b0, last_reg})) begin
                        if (count_reg < CW'(TABLE_DEPTH)) begin
                            mem_we     = 1'b1;
                            last_next  = cand_reg[W-1:0];
                            count_next = count_reg + CW'(1);
                        end else begin
                            full_next = 1'b1;
                        end
                    end
                    if (!test_hi_reg) begin
                        lo_p_next    = test_res;
                        cand_next    = center_reg + PW'(1);
                        test_hi_next = 1'b1;
                        idx_next     = '0;
                        state_next   = S_FETCH;
                    end else begin
                        hi_p_next  = test_res;
                        pos_next   = center_reg + PW'(BLOCK_SIZE);
                        state_next = S_EMIT;
                    end
                end
            end

            S_EMIT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {3'b000, done_reg, full_reg, exh_reg,
                                     hi_p_reg, lo_p_reg, center_ext[31:0]};
                    state_next    = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- sv/wsp_gen_checker.sv -----
// ---------------------------------------------------------------------------
// Wheel-six prime generator port checker
// Watches the stream ports of the core over time; bound to the core module.
// ---------------------------------------------------------------------------
`include "wheel_six_prime_generator_core_defines.svh"

module wsp_gen_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);

    // A stalled result beat holds its value.
    `WSP_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // The core works on one beat at a time.
    `WSP_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)

    // A finished scan reports no test flags.
    `WSP_ASSERT_NOW(a_done_clean, m_tvalid && m_tdata[36], m_tdata[35:32] == 4'b0000)

    // A full table is only reported alongside a prime.
    `WSP_ASSERT_NOW(a_full_with_prime, m_tvalid && m_tdata[35], m_tdata[32] || m_tdata[33])

endmodule

bind wheel_six_prime_generator_core wsp_gen_checker u_wsp_gen_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
